// File: rtl/bwmm_pkg.sv
// Shared constants, codes and the cell-to-cell link type for the bag with min/max.
package bwmm_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 5;

    // Command codes carried on the input tuser.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes reported with every result.
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // Data handed from one cell to the next as the scan wave moves along.
    typedef struct packed {
        logic                     tok;
        logic                     found;
        logic                     has;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } bwmm_link_t;

endpackage

// File: rtl/bwmm_cell.sv
// One storage cell of the chain: holds an entry and takes part in the scan wave.
module bwmm_cell
    import bwmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int UW   = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bwmm_link_t               link_in,
    output bwmm_link_t               link_out,
    input  logic [UW-1:0]            used,
    input  logic                     ins_en,
    input  logic                     rmv,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] next_entry,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     tok_reg;
    bwmm_link_t               data_reg;
    bwmm_link_t               link_next;
    logic                     occ_before;
    logic                     occ_after;
    logic                     match;
    logic                     found_now;
    logic signed [DATA_W-1:0] kept;

    // Occupancy before and after this command, and the first-match test.
    assign occ_before = UW'(IDX) < used;
    assign match      = rmv && occ_before && (entry_reg == value);
    assign found_now  = link_in.found || match;
    assign occ_after  = found_now ? (UW'(IDX + 1) < used) : occ_before;
    assign kept       = found_now ? next_entry : entry_reg;

    // Entry update: append on insert, shift down from the removed entry onward.
    always_comb
    begin
        entry_next = entry_reg;
        if (ins_en && (used == UW'(IDX)))
        begin
            entry_next = value;
        end
        else if (link_in.tok && found_now)
        begin
            entry_next = next_entry;
        end
    end

    // Running minimum and maximum handed on to the next cell.
    always_comb
    begin
        link_next       = link_in;
        link_next.found = found_now;
        if (occ_after)
        begin
            link_next.has = 1'b1;
            link_next.lo  = (!link_in.has || (kept < link_in.lo)) ? kept : link_in.lo;
            link_next.hi  = (!link_in.has || (kept > link_in.hi)) ? kept : link_in.hi;
        end
    end

    // Wave token, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= link_next.tok;
        end
    end

    // Stored entry and link payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        data_reg  <= link_next;
    end

    always_comb
    begin
        link_out     = data_reg;
        link_out.tok = tok_reg;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/bag_with_min_max_top.sv
// Top level of the bag with min/max: command handling, result register and the cell chain.
//
//   Channel   Direction  Signals                     Contents
//   s_*       in         s_tvalid s_tready s_tdata   tdata: value; tuser: cmd
//                        s_tuser
//   m_*       out        m_tvalid m_tready m_tdata   tdata: status, count, empty_res,
//                                                    min_value, max_value
//
// Each command passes three steps: accepting the beat (an insert writes its
// entry here), S_WAVE while the scan wave is launched and passes through the chain
// of cells, where removal shifts and the minimum and maximum are gathered, and S_DONE
// to load the output register. Reset clears the entry count; entries are not cleared.
// A result that is not taken holds the block in S_DONE until m_tready.
module bag_with_min_max_top
    import bwmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] status, [6:2] count, [7] empty_res,
                                   // [39:8] min_value, [71:40] max_value
);

    localparam int UW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAVE,
        S_DONE
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [UW-1:0]            used_reg;
    logic [UW-1:0]            used_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic [CMD_W-1:0]         cmd_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic signed [DATA_W-1:0] res_lo_reg;
    logic signed [DATA_W-1:0] res_lo_next;
    logic signed [DATA_W-1:0] res_hi_reg;
    logic signed [DATA_W-1:0] res_hi_next;
    logic                     start_tok_reg;
    logic                     start_tok_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [71:0]              m_tdata_reg;
    logic [71:0]              m_tdata_next;

    logic                     accept;
    logic                     full;
    logic                     ins_en;
    logic                     rmv;
    logic                     out_free;
    logic signed [DATA_W-1:0] cell_value;
    bwmm_link_t               links [DEPTH+1];
    logic signed [DATA_W-1:0] entries [DEPTH];
    bwmm_link_t               tail;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (used_reg == UW'(DEPTH));
    assign ins_en   = accept && (s_tuser == CMD_INSERT) && !full;
    assign rmv      = (cmd_reg == CMD_REMOVE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign tail     = links[DEPTH];

    // An insert writes the incoming value; the scan wave compares the held one.
    assign cell_value = ins_en ? $signed(s_tdata) : value_reg;

    // Head of the chain: the wave starts with no match and no extremes seen.
    always_comb
    begin
        links[0]       = '0;
        links[0].tok   = start_tok_reg;
    end

    // Chain of cells; during a removal, each cell from the match upward shifts in its upper neighbor's entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] upper;

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = entries[i];
        end
        else
        begin : g_mid
            assign upper = entries[i + 1];
        end

        bwmm_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .link_in    (links[i]),
            .link_out   (links[i + 1]),
            .used       (used_reg),
            .ins_en     (ins_en),
            .rmv        (rmv),
            .value      (cell_value),
            .next_entry (upper),
            .entry      (entries[i])
        );
    end

    // Command sequencing and result formation.
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        res_lo_next    = res_lo_reg;
        res_hi_next    = res_hi_reg;
        start_tok_next = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = s_tuser;
                    value_next     = s_tdata;
                    status_next    = ST_DONE;
                    start_tok_next = 1'b1;
                    state_next     = S_WAVE;
                    if (s_tuser == CMD_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            used_next = used_reg + UW'(1);
                        end
                    end
                    else if (s_tuser == CMD_CLEAR)
                    begin
                        used_next = '0;
                    end
                end
            end
            S_WAVE:
            begin
                if (tail.tok)
                begin
                    if (rmv)
                    begin
                        if (tail.found)
                        begin
                            used_next = used_reg - UW'(1);
                        end
                        else
                        begin
                            status_next = ST_NOMATCH;
                        end
                    end
                    res_lo_next = tail.has ? tail.lo : '0;
                    res_hi_next = tail.has ? tail.hi : '0;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_hi_reg, res_lo_reg, (used_reg == '0),
                                     COUNT_W'(used_reg), status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, count and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            start_tok_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            start_tok_reg <= start_tok_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    // Command payload and pending result.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
